// ===== rtl/tga_rle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the TGA run-length packet encoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

    localparam int MAX_PACKET_DEF = 128;
    localparam int PPR_DEF        = 4;

    localparam int PIX_W      = 32;
    localparam int HDR_W      = 8;
    localparam int CNT_W      = 8;   // holds a packet length up to 128
    localparam int BPP_W      = 3;
    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = 3;   // slot count 0..NUM_SLOTS
    localparam int SLOT_IDX_W = 2;

    localparam logic [BPP_W-1:0] BPP_RESET    = 3'd3;
    localparam logic [HDR_W-1:0] HDR_REP_BASE = 8'd128;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PKT,
        S_WR
    } t_state;

    typedef struct packed {
        logic             rep;
        logic [CNT_W-1:0] n;
    } t_pkt;

endpackage

// ===== rtl/tga_rle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tga_rle_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tga_rle_packet_encoder_unit.sv =====
`timescale 1ns / 1ps
// A closed repeat packet goes from S_PKT into the output register once that is free.
// A raw result of k pixels takes one RAM read per pixel, then loads the output register.
// Throughput: one pixel per cycle while no packet drains; the input stalls during the drain
// of any packet a pixel closes (single read port of the pixel RAM sets the raw drain rate).
// Reset (synchronous, active low) clears control state; the pixel RAM is not cleared.
// ----------------------------------------------------------------------------
// tga_rle_packet_encoder_unit
// TGA run-length packet encoder: repeat/raw packets, header in first result.
// ----------------------------------------------------------------------------
module tga_rle_packet_encoder_unit #(
    parameter int MAX_PACKET        = tga_rle_pkg::MAX_PACKET_DEF,
    parameter int PIXELS_PER_RESULT = tga_rle_pkg::PPR_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tga_rle_pkg::BPP_W-1:0]  i_bytes_per_pixel,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tga_rle_pkg::PIX_W-1:0]  i_pixel,
    input  logic                           i_line_end,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_has_header,
    output logic [tga_rle_pkg::HDR_W-1:0]  o_header_byte,
    output logic [tga_rle_pkg::SLOT_W-1:0] o_pixel_count,
    output logic [tga_rle_pkg::PIX_W-1:0]  o_pixel_a,
    output logic [tga_rle_pkg::PIX_W-1:0]  o_pixel_b,
    output logic [tga_rle_pkg::PIX_W-1:0]  o_pixel_c,
    output logic [tga_rle_pkg::PIX_W-1:0]  o_pixel_d,
    output logic                           o_burst_last
);
    import tga_rle_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PACKET);
    localparam logic [CNT_W-1:0]  MAX_N = CNT_W'(MAX_PACKET);
    localparam logic [SLOT_W-1:0] PPR_N = SLOT_W'(PIXELS_PER_RESULT);

    // control / state registers
    t_state              r_state, n_state;
    logic [BPP_W-1:0]    r_bpp;
    logic [PIX_W-1:0]    r_held;
    logic                r_line_start;
    logic [CNT_W-1:0]    r_raw_len;
    logic [CNT_W-1:0]    r_rep_len;
    logic [PIX_W-1:0]    r_rep_px;
    t_pkt                r_cur, n_cur;
    t_pkt                r_p2, n_p2;
    logic                r_p2_v, n_p2_v;
    logic                r_w2_v, n_w2_v;
    logic [ADDR_W-1:0]   r_w2_addr, n_w2_addr;
    logic [CNT_W-1:0]    r_base, n_base;
    logic [SLOT_W-1:0]   r_issued, n_issued;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_rd_pend;
    logic [PIX_W-1:0]    r_slot_px [NUM_SLOTS];

    // output register
    logic                r_out_valid;
    logic                r_o_has_header;
    logic [HDR_W-1:0]    r_o_header;
    logic [SLOT_W-1:0]   r_o_count;
    logic [PIX_W-1:0]    r_o_px [NUM_SLOTS];
    logic                r_o_last;

    // per-item decision
    logic [PIX_W-1:0]    mask;
    logic [PIX_W-1:0]    pm;
    logic                eq;
    logic [CNT_W-1:0]    rep_inc, raw_inc;
    logic [PIX_W-1:0]    d_held;
    logic                d_ls;
    logic [CNT_W-1:0]    d_raw, d_rep;
    logic                d_w1;
    logic                d_p1_v, d_p2_v, d_w2_v;
    t_pkt                d_p1, d_p2;
    logic [ADDR_W-1:0]   d_w2_addr;

    // drain control
    logic                in_acc;
    logic [CNT_W-1:0]    rem;
    logic [SLOT_W-1:0]   k_cur;
    logic                pkt_last;
    logic                rd_en;
    logic                out_free;
    logic                emit;
    logic                done_pkt;
    logic                more;
    logic [HDR_W-1:0]    hdr;

    // RAM ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [PIX_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [PIX_W-1:0]    ram_rdata;

    tga_rle_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_PACKET)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        case (r_bpp) inside
            3'd0, 3'd1: mask = 32'h0000_00FF;
            3'd2:       mask = 32'h0000_FFFF;
            3'd3:       mask = 32'h00FF_FFFF;
            default:    mask = 32'hFFFF_FFFF;
        endcase
    end

    assign pm      = i_pixel & mask;
    assign eq      = (pm == r_held);
    assign rep_inc = r_rep_len + CNT_W'(1);
    assign raw_inc = r_raw_len + CNT_W'(1);

    // What one pixel does: up to two packets, up to two RAM writes.
    always_comb begin
        d_held    = r_held;
        d_ls      = r_line_start;
        d_raw     = r_raw_len;
        d_rep     = r_rep_len;
        d_w1      = 1'b0;
        d_p1_v    = 1'b0;
        d_p1      = '0;
        d_p2_v    = 1'b0;
        d_p2      = '0;
        d_w2_v    = 1'b0;
        d_w2_addr = '0;
        if (r_line_start) begin
            d_held = pm;
            d_raw  = '0;
            d_rep  = '0;
            d_ls   = 1'b0;
        end else if (r_rep_len != '0) begin
            if (eq) begin
                d_rep = rep_inc;
                if (rep_inc >= MAX_N) begin
                    d_p1_v = 1'b1;
                    d_p1   = '{rep: 1'b1, n: rep_inc};
                    d_rep  = '0;
                    d_ls   = 1'b1;
                end
            end else begin
                d_p1_v = 1'b1;
                d_p1   = '{rep: 1'b1, n: r_rep_len};
                d_rep  = '0;
                d_held = pm;
            end
        end else begin
            if (eq) begin
                if (r_raw_len != '0) begin
                    d_p1_v = 1'b1;
                    d_p1   = '{rep: 1'b0, n: r_raw_len};
                end
                d_raw = '0;
                d_rep = CNT_W'(2);
                if (MAX_N <= CNT_W'(2)) begin
                    d_p2_v = 1'b1;
                    d_p2   = '{rep: 1'b1, n: CNT_W'(2)};
                    d_rep  = '0;
                    d_ls   = 1'b1;
                end
            end else begin
                d_w1   = 1'b1;
                d_raw  = raw_inc;
                d_held = pm;
                if (raw_inc >= MAX_N) begin
                    d_p1_v = 1'b1;
                    d_p1   = '{rep: 1'b0, n: raw_inc};
                    d_raw  = '0;
                end
            end
        end
        // end of line flushes whatever is open
        if (i_line_end && !d_ls) begin
            if (d_rep != '0) begin
                d_p2_v = 1'b1;
                d_p2   = '{rep: 1'b1, n: d_rep};
            end else begin
                d_w2_v    = 1'b1;
                d_w2_addr = ADDR_W'(d_raw);
                d_p2_v    = 1'b1;
                d_p2      = '{rep: 1'b0, n: d_raw + CNT_W'(1)};
            end
            d_raw = '0;
            d_rep = '0;
            d_ls  = 1'b1;
        end
    end

    // drain of the current packet
    assign rem       = r_cur.n - r_base;
    assign k_cur     = (rem > CNT_W'(PPR_N)) ? PPR_N : rem[SLOT_W-1:0];
    assign pkt_last  = (rem <= CNT_W'(PPR_N));
    assign rd_en     = (r_state == S_PKT) && !r_cur.rep && (r_issued < k_cur);
    assign ram_raddr = ADDR_W'(r_base + CNT_W'(r_issued));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit      = (r_state == S_PKT) && out_free && (r_cur.rep || (r_slot == k_cur));
    assign done_pkt  = emit && (r_cur.rep || pkt_last);
    assign more      = r_w2_v || r_p2_v;
    assign hdr       = r_cur.rep ? (HDR_REP_BASE + HDR_W'(r_cur.n) - 8'd1)
                                 : (HDR_W'(r_cur.n) - 8'd1);

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_p2      = r_p2;
        n_p2_v    = r_p2_v;
        n_w2_v    = r_w2_v;
        n_w2_addr = r_w2_addr;
        n_base    = r_base;
        n_issued  = r_issued;
        n_slot    = r_slot;
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(r_raw_len);
        ram_wdata = r_held;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    ram_we    = d_w1;
                    n_w2_v    = d_w2_v;
                    n_w2_addr = d_w2_addr;
                    n_base    = '0;
                    n_issued  = '0;
                    n_slot    = '0;
                    if (d_p1_v) begin
                        n_cur   = d_p1;
                        n_p2    = d_p2;
                        n_p2_v  = d_p2_v;
                        n_state = S_PKT;
                    end else if (d_w2_v) begin
                        n_p2    = d_p2;
                        n_p2_v  = d_p2_v;
                        n_state = S_WR;
                    end else if (d_p2_v) begin
                        n_cur   = d_p2;
                        n_p2_v  = 1'b0;
                        n_state = S_PKT;
                    end
                end
            end
            S_PKT: begin
                if (rd_en) begin
                    n_issued = r_issued + SLOT_W'(1);
                end
                if (r_rd_pend) begin
                    n_slot = r_slot + SLOT_W'(1);
                end
                if (emit) begin
                    n_base   = r_base + CNT_W'(k_cur);
                    n_issued = '0;
                    n_slot   = '0;
                    if (done_pkt) begin
                        n_base = '0;
                        if (r_w2_v) begin
                            n_state = S_WR;
                        end else if (r_p2_v) begin
                            n_cur  = r_p2;
                            n_p2_v = 1'b0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_WR: begin
                // last pixel of the line goes to the store before its raw drain
                ram_we    = 1'b1;
                ram_waddr = r_w2_addr;
                n_w2_v    = 1'b0;
                n_cur     = r_p2;
                n_p2_v    = 1'b0;
                n_base    = '0;
                n_issued  = '0;
                n_slot    = '0;
                n_state   = S_PKT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bpp        <= BPP_RESET;
            r_held       <= '0;
            r_line_start <= 1'b1;
            r_raw_len    <= '0;
            r_rep_len    <= '0;
            r_cur        <= '0;
            r_p2         <= '0;
            r_p2_v       <= 1'b0;
            r_w2_v       <= 1'b0;
            r_w2_addr    <= '0;
            r_base       <= '0;
            r_issued     <= '0;
            r_slot       <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_p2      <= n_p2;
            r_p2_v    <= n_p2_v;
            r_w2_v    <= n_w2_v;
            r_w2_addr <= n_w2_addr;
            r_base    <= n_base;
            r_issued  <= n_issued;
            r_slot    <= n_slot;
            r_rd_pend <= rd_en;
            if (i_cfg_valid) begin
                r_bpp <= i_bytes_per_pixel;
            end
            if (in_acc) begin
                r_held       <= d_held;
                r_line_start <= d_ls;
                r_raw_len    <= d_raw;
                r_rep_len    <= d_rep;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rep_px <= r_held;
        end
        if (r_rd_pend) begin
            r_slot_px[r_slot[SLOT_IDX_W-1:0]] <= ram_rdata;
        end
        if (emit) begin
            r_o_has_header <= r_cur.rep || (r_base == '0);
            r_o_header     <= (r_cur.rep || (r_base == '0)) ? hdr : '0;
            r_o_count      <= r_cur.rep ? SLOT_W'(1) : k_cur;
            r_o_last       <= done_pkt && !more;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (r_cur.rep) begin
                    r_o_px[i] <= (i == 0) ? r_rep_px : '0;
                end else begin
                    r_o_px[i] <= (SLOT_W'(i) < k_cur) ? r_slot_px[i] : '0;
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_has_header  = r_o_has_header;
    assign o_header_byte = r_o_header;
    assign o_pixel_count = r_o_count;
    assign o_pixel_a     = r_o_px[0];
    assign o_pixel_b     = r_o_px[1];
    assign o_pixel_c     = r_o_px[2];
    assign o_pixel_d     = r_o_px[3];
    assign o_burst_last  = r_o_last;

`ifndef SYNTHESIS
    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PKT) |-> !ram_we)
        else $error("pixel store written during packet drain");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_raw_len < MAX_N) && (r_rep_len < MAX_N))
        else $error("run length reached packet limit without flush");

    a_line_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_start |-> ((r_raw_len == '0) && (r_rep_len == '0)))
        else $error("open run while no pixel pending");

    a_capture_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_slot < k_cur))
        else $error("read beat captured past result size");
`endif

endmodule
